// ----- hdl/a2g_pkg.sv -----
// types, token table and match function of the game charset encoder
`default_nettype none

package a2g_pkg;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned MAX_RES    = 3;
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  localparam logic CFG_IDX_MENU_ONLY = 1'b0;

  localparam logic [7:0] NO_MATCH_CODE = 8'h9E;
  localparam logic [7:0] TERM_CODE     = 8'hFF;

  localparam logic [7:0] CH_DIGIT_LO = 8'h30;
  localparam logic [7:0] CH_DIGIT_HI = 8'h39;
  localparam logic [7:0] CH_UPPER_LO = 8'h41;
  localparam logic [7:0] CH_UPPER_HI = 8'h5A;
  localparam logic [7:0] CH_LOWER_LO = 8'h61;
  localparam logic [7:0] CH_LOWER_HI = 8'h7A;
  localparam logic [7:0] UPPER_OFS   = 8'h37;
  localparam logic [7:0] LOWER_OFS   = 8'h3D;

  typedef struct packed {
    logic [7:0] code;
    logic       string_end;
  } res_t;

  typedef struct packed {
    logic [1:0]              cnt;
    res_t [MAX_RES-1:0]      item;
  } push_t;

  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [1:0] len;
    logic [7:0] code;
    logic       menu;
  } tok_t;

  typedef struct packed {
    logic       decided;
    logic [7:0] code;
    logic [1:0] len;
  } match_t;

  localparam int unsigned TOK_COUNT = 37;

  // digits and letters are not in the table; they are handled by range before it
  localparam tok_t TOK_TABLE [TOK_COUNT] = '{
    '{8'h3A, 8'h00, 8'h00, 2'd1, 8'hE6, 1'b0},
    '{8'h29, 8'h28, 8'h00, 2'd2, 8'hE2, 1'b0},
    '{8'h3C, 8'h3C, 8'h00, 2'd2, 8'hF5, 1'b0},
    '{8'h3E, 8'h3E, 8'h00, 2'd2, 8'hF6, 1'b0},
    '{8'h27, 8'h00, 8'h00, 2'd1, 8'h3E, 1'b1},
    '{8'h2E, 8'h00, 8'h00, 2'd1, 8'h3F, 1'b1},
    '{8'h2C, 8'h00, 8'h00, 2'd1, 8'h6F, 1'b1},
    '{8'h20, 8'h00, 8'h00, 2'd1, 8'h9E, 1'b1},
    '{8'h2D, 8'h00, 8'h00, 2'd1, 8'h9F, 1'b1},
    '{8'h28, 8'h00, 8'h00, 2'd1, 8'hE1, 1'b0},
    '{8'h29, 8'h00, 8'h00, 2'd1, 8'hE3, 1'b0},
    '{8'h26, 8'h00, 8'h00, 2'd1, 8'hE5, 1'b1},
    '{8'h21, 8'h00, 8'h00, 2'd1, 8'hF2, 1'b1},
    '{8'h25, 8'h00, 8'h00, 2'd1, 8'hF3, 1'b0},
    '{8'h3F, 8'h00, 8'h00, 2'd1, 8'hF4, 1'b1},
    '{8'h7E, 8'h00, 8'h00, 2'd1, 8'hF7, 1'b0},
    '{8'h2F, 8'h00, 8'h00, 2'd1, 8'hD0, 1'b0},
    '{8'h74, 8'h68, 8'h65, 2'd3, 8'hD1, 1'b0},
    '{8'h79, 8'h6F, 8'h75, 2'd3, 8'hD2, 1'b0},
    '{8'h5B, 8'h25, 8'h5D, 2'd3, 8'hE0, 1'b0},
    '{8'h5B, 8'h41, 8'h5D, 2'd3, 8'h54, 1'b0},
    '{8'h5B, 8'h42, 8'h5D, 2'd3, 8'h55, 1'b0},
    '{8'h5B, 8'h43, 8'h5D, 2'd3, 8'h56, 1'b0},
    '{8'h5B, 8'h5A, 8'h5D, 2'd3, 8'h57, 1'b0},
    '{8'h5B, 8'h52, 8'h5D, 2'd3, 8'h58, 1'b0},
    '{8'h2B, 8'h00, 8'h00, 2'd1, 8'hE4, 1'b0},
    '{8'h5E, 8'h00, 8'h00, 2'd1, 8'h50, 1'b0},
    '{8'h7C, 8'h00, 8'h00, 2'd1, 8'h51, 1'b0},
    '{8'h3C, 8'h00, 8'h00, 2'd1, 8'h52, 1'b0},
    '{8'h3E, 8'h00, 8'h00, 2'd1, 8'h53, 1'b0},
    '{8'h24, 8'h00, 8'h00, 2'd1, 8'hF9, 1'b1},
    '{8'hE2, 8'h98, 8'h85, 2'd3, 8'hFA, 1'b1},
    '{8'h40, 8'h00, 8'h00, 2'd1, 8'hFA, 1'b1},
    '{8'h2A, 8'h00, 8'h00, 2'd1, 8'hFB, 1'b1},
    '{8'hE2, 8'h80, 8'hA2, 2'd3, 8'hFC, 1'b0},
    '{8'h3D, 8'h00, 8'h00, 2'd1, 8'hFD, 1'b0},
    '{8'h0A, 8'h00, 8'h00, 2'd1, 8'hFE, 1'b1}
  };

  function automatic logic prefix_eq(tok_t t, logic [7:0] w0, logic [7:0] w1,
                                     logic [7:0] w2, logic [1:0] l);
    return (w0 == t.b0) && ((l < 2'd2) || (w1 == t.b1)) && ((l < 2'd3) || (w2 == t.b2));
  endfunction

  // first match in table order; undecided when a longer token may still win
  function automatic match_t match_head(logic [7:0] w0, logic [7:0] w1, logic [7:0] w2,
                                        logic [1:0] avail, logic fin, logic menu);
    match_t m;
    logic   done;
    m.decided = 1'b1;
    m.code    = NO_MATCH_CODE;
    m.len     = 2'd1;
    done      = 1'b0;
    if (w0 >= CH_DIGIT_LO && w0 <= CH_DIGIT_HI) begin
      m.code = w0 - CH_DIGIT_LO;
      done   = 1'b1;
    end else if (w0 >= CH_UPPER_LO && w0 <= CH_UPPER_HI) begin
      m.code = w0 - UPPER_OFS;
      done   = 1'b1;
    end else if (!menu && w0 >= CH_LOWER_LO && w0 <= CH_LOWER_HI) begin
      m.code = w0 - LOWER_OFS;
      done   = 1'b1;
    end
    for (int i = 0; i < TOK_COUNT; i++) begin
      if (!done && !(menu && !TOK_TABLE[i].menu)) begin
        if (TOK_TABLE[i].len <= avail) begin
          if (prefix_eq(TOK_TABLE[i], w0, w1, w2, TOK_TABLE[i].len)) begin
            m.code = TOK_TABLE[i].code;
            m.len  = TOK_TABLE[i].len;
            done   = 1'b1;
          end
        end else if (!fin && prefix_eq(TOK_TABLE[i], w0, w1, w2, avail)) begin
          m.decided = 1'b0;
          done      = 1'b1;
        end
      end
    end
    return m;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/a2g_cfg.sv -----
// configuration register block on the apb port
`default_nettype none

module a2g_cfg (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [a2g_pkg::APB_ADDR_W-1:0]    paddr,
  input  wire logic [a2g_pkg::APB_DATA_W-1:0]    pwdata,
  output logic      [a2g_pkg::APB_DATA_W-1:0]    prdata,
  output logic                                   pready,
  output logic                                   menu_only
);

  logic wr_en;
  logic reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[a2g_pkg::APB_ADDR_W-1];
  assign wr_en   = psel && penable && pwrite && (reg_idx == a2g_pkg::CFG_IDX_MENU_ONLY);

  always_ff @(posedge clk) begin
    if (rst) begin
      menu_only <= 1'b0;
    end else if (wr_en) begin
      menu_only <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == a2g_pkg::CFG_IDX_MENU_ONLY) begin
      prdata[0] = menu_only;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/a2g_core.sv -----
// input register, token matching and held-byte state
`default_nettype none

module a2g_core (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic [7:0]    in_byte,
  input  wire logic          menu_only,
  input  wire logic          room,
  output a2g_pkg::push_t     push
);

  logic                 stage_valid;
  logic                 stage_valid_next;
  logic [7:0]           stage_byte;
  logic [1:0]           pending_count;
  logic [1:0]           pending_count_next;
  logic [7:0]           pending_bytes [2];
  logic [7:0]           pend0_next;
  logic [7:0]           pend1_next;

  logic                 load;
  logic                 process;
  logic                 fin;
  logic [7:0]           w0, w1, w2;
  logic [1:0]           n;
  a2g_pkg::match_t      m0, m1, m2, mt;
  logic [1:0]           pos;
  logic [1:0]           cnt;
  logic                 stop;
  a2g_pkg::res_t [a2g_pkg::MAX_RES-1:0] items;

  assign process  = stage_valid && room;
  assign in_stall = stage_valid && !room;
  assign load     = in_valid && !in_stall;
  assign fin      = (stage_byte == 8'h00);

  always_comb begin
    case (pending_count)
      2'd0: begin
        w0 = stage_byte;
        w1 = stage_byte;
        w2 = stage_byte;
      end
      2'd1: begin
        w0 = pending_bytes[0];
        w1 = stage_byte;
        w2 = stage_byte;
      end
      default: begin
        w0 = pending_bytes[0];
        w1 = pending_bytes[1];
        w2 = stage_byte;
      end
    endcase
  end

  assign n  = pending_count + {1'b0, !fin};
  assign m0 = a2g_pkg::match_head(w0, w1, w2, n, fin, menu_only);
  assign m1 = a2g_pkg::match_head(w1, w2, w2, n - 2'd1, fin, menu_only);
  assign m2 = a2g_pkg::match_head(w2, w2, w2, n - 2'd2, fin, menu_only);

  // walk the window: at most three tokens per byte
  always_comb begin
    pos   = 2'd0;
    cnt   = 2'd0;
    stop  = 1'b0;
    mt    = m0;
    items = '0;
    for (int s = 0; s < a2g_pkg::MAX_RES; s++) begin
      if (!stop && pos < n) begin
        case (pos)
          2'd0:    mt = m0;
          2'd1:    mt = m1;
          default: mt = m2;
        endcase
        if (mt.decided) begin
          items[cnt].code       = mt.code;
          items[cnt].string_end = 1'b0;
          cnt = cnt + 2'd1;
          pos = pos + mt.len;
        end else begin
          stop = 1'b1;
        end
      end
    end
    if (fin) begin
      items[cnt].code       = a2g_pkg::TERM_CODE;
      items[cnt].string_end = 1'b1;
      cnt = cnt + 2'd1;
    end
  end

  always_comb begin
    push.item = items;
    push.cnt  = process ? cnt : 2'd0;
  end

  always_comb begin
    pending_count_next = pending_count;
    pend0_next         = pending_bytes[0];
    pend1_next         = pending_bytes[1];
    if (process) begin
      pending_count_next = fin ? 2'd0 : (n - pos);
      case (pos)
        2'd0: begin
          pend0_next = w0;
          pend1_next = w1;
        end
        2'd1: begin
          pend0_next = w1;
          pend1_next = w2;
        end
        default: begin
          pend0_next = w2;
          pend1_next = w2;
        end
      endcase
    end
  end

  always_comb begin
    stage_valid_next = stage_valid;
    if (load) begin
      stage_valid_next = 1'b1;
    end else if (process) begin
      stage_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid   <= 1'b0;
      pending_count <= 2'd0;
    end else begin
      stage_valid   <= stage_valid_next;
      pending_count <= pending_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      stage_byte <= in_byte;
    end
    pending_bytes[0] <= pend0_next;
    pending_bytes[1] <= pend1_next;
  end

  a_pend_max: assert property (@(posedge clk) disable iff (rst)
    pending_count != 2'd3)
    else $error("held byte count out of range");

  a_fin_flush: assert property (@(posedge clk) disable iff (rst)
    process && fin |=> pending_count == 2'd0)
    else $error("terminator left bytes held");

  a_fin_push: assert property (@(posedge clk) disable iff (rst)
    process && fin |-> push.cnt != 2'd0)
    else $error("terminator gave no result");

endmodule

`default_nettype wire

// ----- hdl/a2g_fifo.sv -----
// result queue taking up to three beats per cycle and giving one while out_stall is low
`default_nettype none

module a2g_fifo #(
  parameter int unsigned DEPTH = a2g_pkg::FIFO_DEPTH
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire a2g_pkg::push_t  push,
  output logic                 room,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output logic [7:0]           code,
  output logic                 string_end
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  a2g_pkg::res_t     entries [DEPTH];
  logic [PTR_W-1:0]  rd_ptr;
  logic [PTR_W-1:0]  rd_ptr_next;
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  wr_ptr_next;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic              pop;

  function automatic logic [PTR_W-1:0] ptr_add(logic [PTR_W-1:0] p, logic [1:0] k);
    logic [PTR_W:0] s;
    s = {1'b0, p} + (PTR_W + 1)'(k);
    if (s >= (PTR_W + 1)'(DEPTH)) begin
      s = s - (PTR_W + 1)'(DEPTH);
    end
    return s[PTR_W-1:0];
  endfunction

  assign out_valid  = (count != '0);
  assign pop        = out_valid && !out_stall;
  assign room       = (count <= CNT_W'(DEPTH - a2g_pkg::MAX_RES));
  assign code       = entries[rd_ptr].code;
  assign string_end = entries[rd_ptr].string_end;

  always_comb begin
    wr_ptr_next = ptr_add(wr_ptr, push.cnt);
    rd_ptr_next = pop ? ptr_add(rd_ptr, 2'd1) : rd_ptr;
    count_next  = count + CNT_W'(push.cnt) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      rd_ptr <= rd_ptr_next;
      wr_ptr <= wr_ptr_next;
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < a2g_pkg::MAX_RES; j++) begin
      if (2'(j) < push.cnt) begin
        entries[ptr_add(wr_ptr, 2'(j))] <= push.item[j];
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("result queue overflow");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push.cnt != 2'd0 |-> room)
    else $error("push without room");

endmodule

`default_nettype wire

// ----- hdl/ascii_to_game_charset_encoder_top.sv -----
// top level of the ascii / utf-8 to game charset encoder
//
// input channel: one text byte per beat on in_byte, taken when in_valid is
// high and in_stall is low; a zero byte ends the string
// output channel: one game code per beat on code, string_end marks the 0xff
// terminator, taken when out_valid is high and out_stall is low
// a byte gives zero to three result beats; bytes that may start a longer
// token are held until later bytes decide the match
// a byte's results pass the input register and then the result queue
// throughput: one byte per cycle while each byte gives at most one result
// and the receiver does not stall; the output port moves one beat per cycle,
// and the queue must have room for three beats before a byte is matched
// menu_only is written over apb (address 0, bit 0); the user writes it only
// while the block is idle, which the block itself does not enforce
// reset clears held bytes, the queue and menu_only; no clearing pass
// when the receiver stalls, the queue fills and in_stall rises
`default_nettype none

module ascii_to_game_charset_encoder_top #(
  parameter int unsigned FIFO_DEPTH = a2g_pkg::FIFO_DEPTH
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [a2g_pkg::APB_ADDR_W-1:0]    paddr,
  input  wire logic [a2g_pkg::APB_DATA_W-1:0]    pwdata,
  output logic      [a2g_pkg::APB_DATA_W-1:0]    prdata,
  output logic                                   pready,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [7:0]                        in_byte,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [7:0]                             code,
  output logic                                   string_end
);

  logic            menu_only;
  logic            room;
  a2g_pkg::push_t  push;

  a2g_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .menu_only (menu_only)
  );

  a2g_core u_core (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_byte   (in_byte),
    .menu_only (menu_only),
    .room      (room),
    .push      (push)
  );

  a2g_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .room       (room),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .code       (code),
    .string_end (string_end)
  );

endmodule

`default_nettype wire

// ----- bench/tb_ascii_to_game_charset_encoder_top.sv -----
// self-checking testbench for the ascii / utf-8 to game charset encoder
`default_nettype none

module tb_ascii_to_game_charset_encoder_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [a2g_pkg::APB_ADDR_W-1:0] MENU_ONLY_ADDR =
    a2g_pkg::APB_ADDR_W'(4 * a2g_pkg::CFG_IDX_MENU_ONLY);
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 120;
  localparam int PHASES       = 6;
  localparam int PHASE_BYTES  = 52;

  typedef struct packed {
    logic [2:0][7:0] b;
    logic [1:0]      len;
    logic [7:0]      code;
    bit              menu;
  } glyph_tok_t;

  typedef enum bit {ROW_BYTE, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t  kind;
    logic [7:0] val;
    bit         typed;
    logic [1:0] n_typed;
    logic [7:0] t0;
    logic [7:0] t1;
  } stim_row_t;

  localparam stim_row_t DIR_ROWS [25] = '{
    '{ROW_BYTE, 8'h00, 1'b1, 2'd1, a2g_pkg::TERM_CODE, 8'h00},
    '{ROW_BYTE, "A", 1'b1, 2'd1, 8'h0A, 8'h00},
    '{ROW_BYTE, "0", 1'b1, 2'd1, 8'h00, 8'h00},
    '{ROW_BYTE, 8'hFF, 1'b1, 2'd1, a2g_pkg::NO_MATCH_CODE, 8'h00},
    '{ROW_BYTE, 8'h01, 1'b1, 2'd1, a2g_pkg::NO_MATCH_CODE, 8'h00},
    '{ROW_BYTE, ")", 1'b0, 2'd0, 8'h00, 8'h00},
    '{ROW_BYTE, "(", 1'b0, 2'd0, 8'h00, 8'h00},
    '{ROW_BYTE, "<", 1'b0, 2'd0, 8'h00, 8'h00},
    '{ROW_BYTE, "<", 1'b0, 2'd0, 8'h00, 8'h00},
    '{ROW_BYTE, "[", 1'b0, 2'd0, 8'h00, 8'h00},
    '{ROW_BYTE, "A", 1'b0, 2'd0, 8'h00, 8'h00},
    '{ROW_BYTE, "]", 1'b0, 2'd0, 8'h00, 8'h00},
    '{ROW_BYTE, 8'hE2, 1'b0, 2'd0, 8'h00, 8'h00},
    '{ROW_BYTE, 8'h98, 1'b0, 2'd0, 8'h00, 8'h00},
    '{ROW_BYTE, 8'h85, 1'b0, 2'd0, 8'h00, 8'h00},
    '{ROW_BYTE, "t", 1'b0, 2'd0, 8'h00, 8'h00},
    '{ROW_BYTE, "h", 1'b0, 2'd0, 8'h00, 8'h00},
    '{ROW_BYTE, "e", 1'b0, 2'd0, 8'h00, 8'h00},
    '{ROW_BYTE, 8'h00, 1'b1, 2'd1, a2g_pkg::TERM_CODE, 8'h00},
    '{ROW_BYTE, "[", 1'b0, 2'd0, 8'h00, 8'h00},
    '{ROW_BYTE, 8'h00, 1'b1, 2'd2, a2g_pkg::NO_MATCH_CODE, a2g_pkg::TERM_CODE},
    '{ROW_BYTE, "<", 1'b0, 2'd0, 8'h00, 8'h00},
    '{ROW_CFG, 8'h01, 1'b0, 2'd0, 8'h00, 8'h00},
    '{ROW_BYTE, "a", 1'b0, 2'd0, 8'h00, 8'h00},
    '{ROW_BYTE, 8'h00, 1'b0, 2'd0, 8'h00, 8'h00}
  };

  logic [7:0] punct_set [28] = '{":", "'", ".", ",", " ", "-", "(", ")", "&", "!",
                                 "%", "?", "~", "/", "+", "^", "|", "<", ">", "$",
                                 "@", "*", "=", "\n", "[", "]", "#", "\""};

  logic                           clk = 1'b0;
  logic                           rst;
  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [a2g_pkg::APB_ADDR_W-1:0] paddr;
  logic [a2g_pkg::APB_DATA_W-1:0] pwdata;
  logic [a2g_pkg::APB_DATA_W-1:0] prdata;
  logic                           pready;
  logic                           in_valid;
  logic                           in_stall;
  logic [7:0]                     in_byte;
  logic                           out_valid;
  logic                           out_stall;
  logic [7:0]                     code;
  logic                           string_end;

  glyph_tok_t      tok_list [$];
  a2g_pkg::res_t   code_q [$];
  logic [7:0]      held_bytes [2];
  int              held_cnt;
  bit              menu_sel;

  int fail_count;
  int beats_checked;
  int bytes_sent;
  int strings_sent;
  int in_stall_cycles;
  int burst_left;
  bit no_gaps;
  bit hold_off_req;
  int hold_count;

  ascii_to_game_charset_encoder_top dut (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_byte   (in_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .code      (code),
    .string_end(string_end)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    fail_count++;
  endtask

  function automatic void add_tok(input logic [7:0] b0, input logic [7:0] b1,
                                  input logic [7:0] b2, input logic [1:0] len,
                                  input logic [7:0] c, input bit m);
    glyph_tok_t t;
    t.b[0] = b0;
    t.b[1] = b1;
    t.b[2] = b2;
    t.len  = len;
    t.code = c;
    t.menu = m;
    tok_list.push_back(t);
  endfunction

  function automatic bit head_eq(input glyph_tok_t t, input logic [7:0] w [3],
                                 input int pos, input int n);
    for (int j = 0; j < n; j++)
      if (w[pos + j] != t.b[j]) return 1'b0;
    return 1'b1;
  endfunction

  // first entry in table order wins; 0 means a longer token is still possible
  function automatic bit resolve_head(input logic [7:0] w [3], input int pos,
                                      input int avail, input bit fin,
                                      output logic [7:0] c, output int l);
    c = a2g_pkg::NO_MATCH_CODE;
    l = 1;
    foreach (tok_list[i]) begin
      if (menu_sel && !tok_list[i].menu) continue;
      if (int'(tok_list[i].len) <= avail) begin
        if (head_eq(tok_list[i], w, pos, int'(tok_list[i].len))) begin
          c = tok_list[i].code;
          l = int'(tok_list[i].len);
          return 1'b1;
        end
      end else if (!fin && head_eq(tok_list[i], w, pos, avail)) begin
        return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  function automatic void encode_byte(input logic [7:0] b, input bit queue_it);
    logic [7:0] w [3];
    logic [7:0] c;
    int         n;
    int         pos;
    int         l;
    bit         fin;
    fin  = (b == 8'h00);
    n    = held_cnt;
    w[0] = held_bytes[0];
    w[1] = held_bytes[1];
    w[2] = 8'h00;
    if (!fin) begin
      w[n] = b;
      n++;
    end
    pos = 0;
    while (pos < n) begin
      if (!resolve_head(w, pos, n - pos, fin, c, l)) break;
      if (queue_it) code_q.push_back('{code: c, string_end: 1'b0});
      pos += l;
    end
    held_cnt = n - pos;
    for (int i = 0; i < held_cnt; i++) held_bytes[i] = w[pos + i];
    if (fin) begin
      held_cnt = 0;
      if (queue_it) code_q.push_back('{code: a2g_pkg::TERM_CODE, string_end: 1'b1});
    end
  endfunction

  task automatic offer_byte(input logic [7:0] b, input bit queue_it);
    int gap;
    @(negedge clk);
    in_valid = 1'b1;
    in_byte  = b;
    do @(posedge clk); while (in_stall);
    encode_byte(b, queue_it);
    bytes_sent++;
    if (b == 8'h00) strings_sent++;
    if (!no_gaps) begin
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap        = $urandom_range(1, 6);
        @(negedge clk);
        in_valid = 1'b0;
        in_byte  = 8'($urandom);
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (code_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apb_cycle(input bit wr, input logic [31:0] d, output logic [31:0] rd);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = MENU_ONLY_ADDR;
    pwdata  = d;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic set_menu(input bit v);
    logic [31:0] rd;
    apb_cycle(1'b1, 32'(v), rd);
    menu_sel = v;
    apb_cycle(1'b0, 32'h0, rd);
    if (rd !== 32'(v)) report_mismatch("menu_only readback", rd, 32'(v));
  endtask

  task automatic send_string(input int max_pieces);
    logic [7:0] s [$];
    int         kind;
    s.delete();
    repeat ($urandom_range(1, max_pieces)) begin
      kind = $urandom_range(0, 11);
      case (kind)
        0: s.push_back(8'("A" + $urandom_range(0, 25)));
        1, 11: s.push_back(8'("a" + $urandom_range(0, 25)));
        2: s.push_back(8'("0" + $urandom_range(0, 9)));
        3: s.push_back(punct_set[$urandom_range(0, 27)]);
        4: begin
          case ($urandom_range(0, 2))
            0: begin s.push_back(")"); s.push_back("("); end
            1: begin s.push_back("<"); s.push_back("<"); end
            default: begin s.push_back(">"); s.push_back(">"); end
          endcase
        end
        5: begin
          s.push_back("[");
          case ($urandom_range(0, 6))
            0: s.push_back("%");
            1: s.push_back("A");
            2: s.push_back("B");
            3: s.push_back("C");
            4: s.push_back("Z");
            5: s.push_back("R");
            default: s.push_back(8'($urandom_range(1, 255)));
          endcase
          if ($urandom_range(0, 9) != 0) s.push_back("]");
        end
        6: begin s.push_back(8'hE2); s.push_back(8'h98); s.push_back(8'h85); end
        7: begin s.push_back(8'hE2); s.push_back(8'h80); s.push_back(8'hA2); end
        8: begin
          s.push_back(8'hE2);
          if ($urandom_range(0, 1)) s.push_back($urandom_range(0, 1) ? 8'h98 : 8'h80);
          s.push_back(8'($urandom_range(1, 255)));
        end
        9: begin
          if ($urandom_range(0, 1)) begin
            s.push_back("t"); s.push_back("h"); s.push_back("e");
          end else begin
            s.push_back("y"); s.push_back("o"); s.push_back("u");
          end
        end
        default: s.push_back(8'($urandom_range(1, 255)));
      endcase
    end
    // leave a token prefix open so the terminator cuts it
    if ($urandom_range(0, 4) == 0) begin
      case ($urandom_range(0, 4))
        0: s.push_back("[");
        1: s.push_back(8'hE2);
        2: begin s.push_back(8'hE2); s.push_back(8'h98); end
        3: s.push_back(")");
        default: begin s.push_back("["); s.push_back("B"); end
      endcase
    end
    s.push_back(8'h00);
    foreach (s[i]) offer_byte(s[i], 1'b1);
  endtask

  // result checker
  always @(posedge clk) begin : result_check
    a2g_pkg::res_t want;
    if (!rst) begin
      if (in_valid && in_stall) in_stall_cycles++;
      if (out_valid && !out_stall) begin
        if (code_q.size() == 0) begin
          report_mismatch("unexpected result beat", 32'(code), 32'h0);
        end else begin
          want = code_q.pop_front();
          if (code !== want.code) report_mismatch("code", 32'(code), 32'(want.code));
          if (string_end !== want.string_end)
            report_mismatch("string_end", 32'(string_end), 32'(want.string_end));
          beats_checked++;
        end
      end
    end
  end

  // receiver stall pattern
  initial begin : rx_stall
    int mode;
    int span;
    out_stall = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(5, 40);
      repeat (span) begin
        @(negedge clk);
        if (hold_off_req) begin
          out_stall = 1'b1;
          repeat (HOLD_CYCLES) @(negedge clk);
          hold_off_req = 1'b0;
          hold_count++;
        end
        case (mode)
          0: out_stall = 1'b0;
          1: out_stall = ($urandom_range(0, 3) == 0);
          2: out_stall = ($urandom_range(0, 9) < 6);
          default: out_stall = ~out_stall;
        endcase
      end
    end
  end

  initial begin : watchdog
    #2_000_000;
    $display("timeout with %0d results still expected", code_q.size());
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : main_seq
    logic [31:0] rd;
    rst          = 1'b1;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    in_valid     = 1'b0;
    in_byte      = 8'h00;
    hold_off_req = 1'b0;
    no_gaps      = 1'b0;
    burst_left   = 4;
    menu_sel     = 1'b0;
    held_cnt     = 0;
    held_bytes   = '{8'h00, 8'h00};

    for (int c = 0; c < 10; c++) add_tok(8'("0" + c), 8'h00, 8'h00, 2'd1, 8'(c), 1'b1);
    for (int c = 0; c < 26; c++) add_tok(8'("A" + c), 8'h00, 8'h00, 2'd1, 8'(c + 10), 1'b1);
    for (int c = 0; c < 26; c++) add_tok(8'("a" + c), 8'h00, 8'h00, 2'd1, 8'(c + 36), 1'b0);
    add_tok(":", 8'h00, 8'h00, 2'd1, 8'hE6, 1'b0);
    add_tok(")", "(", 8'h00, 2'd2, 8'hE2, 1'b0);
    add_tok("<", "<", 8'h00, 2'd2, 8'hF5, 1'b0);
    add_tok(">", ">", 8'h00, 2'd2, 8'hF6, 1'b0);
    add_tok("'", 8'h00, 8'h00, 2'd1, 8'h3E, 1'b1);
    add_tok(".", 8'h00, 8'h00, 2'd1, 8'h3F, 1'b1);
    add_tok(",", 8'h00, 8'h00, 2'd1, 8'h6F, 1'b1);
    add_tok(" ", 8'h00, 8'h00, 2'd1, 8'h9E, 1'b1);
    add_tok("-", 8'h00, 8'h00, 2'd1, 8'h9F, 1'b1);
    add_tok("(", 8'h00, 8'h00, 2'd1, 8'hE1, 1'b0);
    add_tok(")", 8'h00, 8'h00, 2'd1, 8'hE3, 1'b0);
    add_tok("&", 8'h00, 8'h00, 2'd1, 8'hE5, 1'b1);
    add_tok("!", 8'h00, 8'h00, 2'd1, 8'hF2, 1'b1);
    add_tok("%", 8'h00, 8'h00, 2'd1, 8'hF3, 1'b0);
    add_tok("?", 8'h00, 8'h00, 2'd1, 8'hF4, 1'b1);
    add_tok("~", 8'h00, 8'h00, 2'd1, 8'hF7, 1'b0);
    add_tok("/", 8'h00, 8'h00, 2'd1, 8'hD0, 1'b0);
    add_tok("t", "h", "e", 2'd3, 8'hD1, 1'b0);
    add_tok("y", "o", "u", 2'd3, 8'hD2, 1'b0);
    add_tok("[", "%", "]", 2'd3, 8'hE0, 1'b0);
    add_tok("[", "A", "]", 2'd3, 8'h54, 1'b0);
    add_tok("[", "B", "]", 2'd3, 8'h55, 1'b0);
    add_tok("[", "C", "]", 2'd3, 8'h56, 1'b0);
    add_tok("[", "Z", "]", 2'd3, 8'h57, 1'b0);
    add_tok("[", "R", "]", 2'd3, 8'h58, 1'b0);
    add_tok("+", 8'h00, 8'h00, 2'd1, 8'hE4, 1'b0);
    add_tok("^", 8'h00, 8'h00, 2'd1, 8'h50, 1'b0);
    add_tok("|", 8'h00, 8'h00, 2'd1, 8'h51, 1'b0);
    add_tok("<", 8'h00, 8'h00, 2'd1, 8'h52, 1'b0);
    add_tok(">", 8'h00, 8'h00, 2'd1, 8'h53, 1'b0);
    add_tok("$", 8'h00, 8'h00, 2'd1, 8'hF9, 1'b1);
    add_tok(8'hE2, 8'h98, 8'h85, 2'd3, 8'hFA, 1'b1);
    add_tok("@", 8'h00, 8'h00, 2'd1, 8'hFA, 1'b1);
    add_tok("*", 8'h00, 8'h00, 2'd1, 8'hFB, 1'b1);
    add_tok(8'hE2, 8'h80, 8'hA2, 2'd3, 8'hFC, 1'b0);
    add_tok("=", 8'h00, 8'h00, 2'd1, 8'hFD, 1'b0);
    add_tok("\n", 8'h00, 8'h00, 2'd1, 8'hFE, 1'b1);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    apb_cycle(1'b0, 32'h0, rd);
    if (rd !== 32'h0) report_mismatch("menu_only after reset", rd, 32'h0);

    // directed table
    foreach (DIR_ROWS[r]) begin
      if (DIR_ROWS[r].kind == ROW_CFG) begin
        wait_idle();
        set_menu(DIR_ROWS[r].val[0]);
      end else if (DIR_ROWS[r].typed) begin
        for (int k = 0; k < DIR_ROWS[r].n_typed; k++)
          code_q.push_back('{code: (k == 0) ? DIR_ROWS[r].t0 : DIR_ROWS[r].t1,
                             string_end: (DIR_ROWS[r].val == 8'h00 &&
                                          k == DIR_ROWS[r].n_typed - 1)});
        offer_byte(DIR_ROWS[r].val, 1'b0);
      end else begin
        offer_byte(DIR_ROWS[r].val, 1'b1);
      end
    end

    // random strings, menu_only toggled per phase, one phase with a long receiver hold
    for (int p = 0; p < PHASES; p++) begin : phase_loop
      int start_bytes;
      wait_idle();
      set_menu(p % 2 == 1);
      if (p == 2) begin
        no_gaps      = 1'b1;
        hold_off_req = 1'b1;
      end
      start_bytes = bytes_sent;
      while (bytes_sent - start_bytes < PHASE_BYTES) send_string(8);
      no_gaps = 1'b0;
    end

    wait_idle();
    $display("covered %0d strings, %0d bytes and %0d result beats over both menu modes",
             strings_sent, bytes_sent, beats_checked);
    $display("input back-pressure seen on %0d cycles, %0d long receiver hold(s)",
             in_stall_cycles, hold_count);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
